@@ design/egps_pkg.sv @@
// ---------------------------------------------------------------------------
// egps_pkg
// Shared types and constants for the elliptical gradient pixel shader.
// ---------------------------------------------------------------------------
package egps_pkg;

	// coordinate range of the raster
	localparam int MAX_DIM = 4096;
	localparam int COORD_W = 12;
	localparam logic [COORD_W-1:0] COORD_MAX =
		(MAX_DIM >= (1 << COORD_W)) ? {COORD_W{1'b1}} : COORD_W'(MAX_DIM - 1);

	// default number of gradient levels
	localparam int LUT_ENTRIES_DEF = 256;

	// fixed point
	localparam int FRAC_W = 24;
	localparam int UNIT_W = FRAC_W + 1;       // holds 0..1.0 inclusive
	localparam logic [UNIT_W-1:0] ONE_Q24 = UNIT_W'(1) << FRAC_W;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// total pipeline depth, input word to output register
	localparam int PIPE_DEPTH = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_INV_RADIUS_X  = 3'd2,
		REG_INV_RADIUS_Y  = 3'd3,
		REG_VIGNETTE_ROWS = 3'd4,
		REG_INV_VIG_ROWS  = 3'd5,
		REG_CENTER_COLOR  = 3'd6,
		REG_EDGE_COLOR    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_radius_x;
		logic [23:0] inv_radius_y;
		logic [12:0] vignette_rows;
		logic [23:0] inv_vignette_rows;
		logic [23:0] center_color;
		logic [23:0] edge_color;
	} cfg_t;

	// vignette control handed from the geometry pipe to the shading pipe
	typedef struct packed {
		logic              dark;
		logic [UNIT_W-1:0] scale;
	} vig_ctl_t;

endpackage

@@ design/egps_cfg.sv @@
// ---------------------------------------------------------------------------
// egps_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module egps_cfg import egps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CENTER_X:      cfg_q.center_x          <= cfg_wdata[15:0];
				REG_CENTER_Y:      cfg_q.center_y          <= cfg_wdata[15:0];
				REG_INV_RADIUS_X:  cfg_q.inv_radius_x      <= cfg_wdata;
				REG_INV_RADIUS_Y:  cfg_q.inv_radius_y      <= cfg_wdata;
				REG_VIGNETTE_ROWS: cfg_q.vignette_rows     <= cfg_wdata[12:0];
				REG_INV_VIG_ROWS:  cfg_q.inv_vignette_rows <= cfg_wdata;
				REG_CENTER_COLOR:  cfg_q.center_color      <= cfg_wdata;
				REG_EDGE_COLOR:    cfg_q.edge_color        <= cfg_wdata;
				default:           cfg_q                   <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/egps_geom.sv @@
// ---------------------------------------------------------------------------
// egps_geom
// Six-stage geometry pipe: elliptical distance to gradient index, plus the
// vignette scale of the row.
// ---------------------------------------------------------------------------
module egps_geom import egps_pkg::*; #(
	parameter int LUT_ENTRIES = LUT_ENTRIES_DEF,
	parameter int IDX_W       = $clog2(LUT_ENTRIES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   idx,
	output vig_ctl_t           vig
);

	localparam int PROD_W = UNIT_W + IDX_W;
	localparam logic [IDX_W-1:0] LEVEL_MAX = IDX_W'(LUT_ENTRIES - 1);

	// stage valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !v_s6 || out_ready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign in_ready  = adv1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: clamp, offset from center, vignette product
	logic [COORD_W-1:0] col_c, row_c;
	logic [15:0]        pos_x, pos_y, dx, dy;
	logic [15:0]        dx_s1, dy_s1;
	logic [35:0]        p_s1;
	logic               dark_s1;

	always_comb begin
		col_c = (col > COORD_MAX) ? COORD_MAX : col;
		row_c = (row > COORD_MAX) ? COORD_MAX : row;
		pos_x = {col_c, 4'b0};
		pos_y = {row_c, 4'b0};
		dx    = (pos_x >= cfg.center_x) ? pos_x - cfg.center_x : cfg.center_x - pos_x;
		dy    = (pos_y >= cfg.center_y) ? pos_y - cfg.center_y : cfg.center_y - pos_y;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dx_s1   <= dx;
			dy_s1   <= dy;
			p_s1    <= 36'(row_c) * 36'(cfg.inv_vignette_rows);
			dark_s1 <= {1'b0, row_c} < cfg.vignette_rows;
		end
	end

	// stage 2: normalized axis offsets, saturated at 1.0
	logic [39:0]       mx, my;
	logic [UNIT_W-1:0] ax_s2, ay_s2, f_s2;
	logic              dark_s2;

	always_comb begin
		mx = 40'(dx_s1) * 40'(cfg.inv_radius_x);
		my = 40'(dy_s1) * 40'(cfg.inv_radius_y);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ax_s2   <= (mx[39:4] > 36'(ONE_Q24)) ? ONE_Q24 : mx[28:4];
			ay_s2   <= (my[39:4] > 36'(ONE_Q24)) ? ONE_Q24 : my[28:4];
			f_s2    <= (p_s1 >= 36'(ONE_Q24)) ? '0 : UNIT_W'(36'(ONE_Q24) - p_s1);
			dark_s2 <= dark_s1;
		end
	end

	// stage 3: squares
	logic [49:0]       sqx, sqy, sqf;
	logic [UNIT_W-1:0] sx_s3, sy_s3;
	logic [23:0]       h_s3;
	logic              dark_s3;

	always_comb begin
		sqx = 50'(ax_s2) * 50'(ax_s2);
		sqy = 50'(ay_s2) * 50'(ay_s2);
		sqf = 50'(f_s2) * 50'(f_s2);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			sx_s3   <= sqx[48:24];
			sy_s3   <= sqy[48:24];
			h_s3    <= sqf[48:25];
			dark_s3 <= dark_s2;
		end
	end

	// stage 4: sum with clamp, scale = 1 - f^2/2
	logic [UNIT_W:0]   ssum;
	logic [UNIT_W-1:0] s_s4;
	vig_ctl_t          vig_s4;

	assign ssum = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk) begin
		if (adv4) begin
			s_s4         <= (ssum > {1'b0, ONE_Q24}) ? ONE_Q24 : ssum[UNIT_W-1:0];
			vig_s4.dark  <= dark_s3;
			vig_s4.scale <= ONE_Q24 - {1'b0, h_s3};
		end
	end

	// stage 5: d = s^2
	logic [49:0]       sqs;
	logic [UNIT_W-1:0] d_s5;
	vig_ctl_t          vig_s5;

	assign sqs = 50'(s_s4) * 50'(s_s4);

	always_ff @(posedge clk) begin
		if (adv5) begin
			d_s5   <= sqs[48:24];
			vig_s5 <= vig_s4;
		end
	end

	// stage 6: gradient level, at most LUT_ENTRIES-1
	logic [PROD_W-1:0] lvl;
	logic [IDX_W-1:0]  idx_s6;
	vig_ctl_t          vig_s6;

	assign lvl = PROD_W'(d_s5) * PROD_W'(LEVEL_MAX);

	always_ff @(posedge clk) begin
		if (adv6) begin
			idx_s6 <= lvl[FRAC_W +: IDX_W];
			vig_s6 <= vig_s5;
		end
	end

	assign idx = idx_s6;
	assign vig = vig_s6;

endmodule

@@ design/egps_shade.sv @@
// ---------------------------------------------------------------------------
// egps_shade
// Three-stage shading pipe: color blend, divide by level count, vignette.
// ---------------------------------------------------------------------------
module egps_shade import egps_pkg::*; #(
	parameter int LUT_ENTRIES = LUT_ENTRIES_DEF,
	parameter int IDX_W       = $clog2(LUT_ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] idx,
	input  vig_ctl_t         vig,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	// blend numerator width and reciprocal for the exact floor divide by LEVELS
	localparam int NUM_W = 8 + IDX_W;
	localparam int SHIFT = NUM_W + IDX_W;
	localparam int RCP_W = SHIFT - IDX_W + 2;
	localparam int MUL_W = NUM_W + RCP_W;
	localparam longint unsigned LEVELS = longint'(LUT_ENTRIES - 1);
	localparam longint unsigned RCP_FULL = ((64'd1 << SHIFT) + LEVELS - 1) / LEVELS;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
	localparam logic [IDX_W-1:0] LEVEL_MAX = IDX_W'(LUT_ENTRIES - 1);

	logic v_s7, v_s8, v_s9;
	logic adv7, adv8, adv9;

	assign adv9 = !v_s9 || out_ready;
	assign adv8 = !v_s8 || adv9;
	assign adv7 = !v_s7 || adv8;

	assign in_ready  = adv7;
	assign out_valid = v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (adv7) v_s7 <= in_valid;
			if (adv8) v_s8 <= v_s7;
			if (adv9) v_s9 <= v_s8;
		end
	end

	// channel n sits at bits 23-8n .. 16-8n of the packed colors
	logic [NUM_W-1:0] num_s7 [3];
	logic [7:0]       q_s8   [3];
	logic [7:0]       ch_s9  [3];
	vig_ctl_t         vig_s7, vig_s8;
	logic [IDX_W-1:0] idx_inv;
	logic [NUM_W-1:0] num    [3];
	logic [MUL_W-1:0] qprod  [3];
	logic [32:0]      dprod  [3];

	assign idx_inv = LEVEL_MAX - idx;

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			num[n]   = NUM_W'(cfg.center_color[16-8*n +: 8]) * NUM_W'(idx_inv)
			         + NUM_W'(cfg.edge_color[16-8*n +: 8]) * NUM_W'(idx);
			qprod[n] = MUL_W'(num_s7[n]) * MUL_W'(RCP);
			dprod[n] = 33'(q_s8[n]) * 33'(vig_s8.scale);
		end
	end

	// stage 7: weighted sum
	always_ff @(posedge clk) begin
		if (adv7) begin
			num_s7 <= num;
			vig_s7 <= vig;
		end
	end

	// stage 8: floor divide by the level count
	always_ff @(posedge clk) begin
		if (adv8) begin
			for (int n = 0; n < 3; n++) q_s8[n] <= qprod[n][SHIFT +: 8];
			vig_s8 <= vig_s7;
		end
	end

	// stage 9: vignette darkening
	always_ff @(posedge clk) begin
		if (adv9) begin
			for (int n = 0; n < 3; n++)
				ch_s9[n] <= vig_s8.dark ? dprod[n][31:24] : q_s8[n];
		end
	end

	assign red   = ch_s9[0];
	assign green = ch_s9[1];
	assign blue  = ch_s9[2];

endmodule

@@ design/elliptical_gradient_pixel_shader.sv @@
// ---------------------------------------------------------------------------
// elliptical_gradient_pixel_shader
// An accepted pixel word moves through stages 1-9 to its color word on the port.
// Throughput: one pixel per clock while the color port does not stall; every
// stage but the sum stage holds one multiply row.
// Stalls hold in place; bubbles are squeezed out, so input is taken while a
// finished word waits as long as some stage is empty.
// Reset (arst_n low, async): pipeline emptied, all config registers zero.
// ---------------------------------------------------------------------------
module elliptical_gradient_pixel_shader import egps_pkg::*; #(
	parameter int LUT_ENTRIES = LUT_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// pixel coordinate channel
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  logic [COORD_W-1:0]    col,
	input  logic [COORD_W-1:0]    row,
	// color channel
	output logic                  rgb_valid,
	input  logic                  rgb_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [7:0]            alpha
);

	// number of bits in the gradient level
	localparam int IDX_W = (LUT_ENTRIES > 1) ? $clog2(LUT_ENTRIES) : 1;

	cfg_t             cfg;
	logic             mid_valid, mid_ready;
	logic [IDX_W-1:0] mid_idx;
	vig_ctl_t         mid_vig;

	// register file; the user must write it only while the pipe is drained, the block does not enforce this
	egps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stages 1-6: distance -> gradient level, row -> vignette scale
	egps_geom #(
		.LUT_ENTRIES (LUT_ENTRIES),
		.IDX_W       (IDX_W)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.col       (col),
		.row       (row),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.idx       (mid_idx),
		.vig       (mid_vig)
	);

	// stages 7-9: blend, divide, darken; stage 9 is the output register
	egps_shade #(
		.LUT_ENTRIES (LUT_ENTRIES),
		.IDX_W       (IDX_W)
	) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.idx       (mid_idx),
		.vig       (mid_vig),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// background is always opaque
	assign alpha = 8'hFF;

endmodule

@@ design/egps_checker.sv @@
// ---------------------------------------------------------------------------
// egps_checker
// Port-level checks on the shader: occupancy, opacity, output hold.
// ---------------------------------------------------------------------------
module egps_checker import egps_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       rgb_valid,
	input logic       rgb_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc, out_acc;

	assign in_acc  = pix_valid && pix_ready;
	assign out_acc = rgb_valid && rgb_ready;

	// words inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> alpha == 8'hFF)
		else $error("alpha not opaque");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable({red, green, blue}))
		else $error("stalled color word changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> cnt_q != '0)
		else $error("color word with no pixel inside");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> pix_ready)
		else $error("empty pipe refuses input");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words inside than stages");

endmodule

bind elliptical_gradient_pixel_shader egps_checker u_egps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.alpha     (alpha)
);
